/* design/ffsa_pkg.sv */
package ffsa_pkg;

	// Widths fixed by the request and result fields
	localparam int unsigned LEN_W   = 5;
	localparam int unsigned START_W = 4;
	localparam int unsigned CAP_W   = 5;
	localparam int unsigned OCC_W   = 16;
	// Start indexes are 4 bits wide, so no run may be placed above slot 15
	localparam int unsigned MAX_SCAN = 16;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC_SCAN,
		ST_ALLOC_FILL,
		ST_FREE_SCAN,
		ST_FREE_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               kind;
		logic [LEN_W-1:0]   run_length;
		logic [START_W-1:0] run_start;
		logic [CAP_W-1:0]   cap;
	} eng_req_t;

	typedef struct packed {
		logic               busy;
		logic               res_valid;
		logic               alloc;
		logic               success;
		logic [START_W-1:0] granted_start;
		logic [OCC_W-1:0]   occupancy;
	} eng_stat_t;

endpackage

/* design/ffsa_ram.sv */
module ffsa_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/ffsa_engine.sv */
module ffsa_engine
	import ffsa_pkg::*;
#(
	parameter int unsigned SLOTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  eng_req_t  req,
	input  logic      res_ready,
	output eng_stat_t stat
);

	localparam int unsigned IW = $clog2(SLOTS);

	state_t state_q, state_nx;

	logic [SLOTS-1:0]   used_q;
	logic [CAP_W-1:0]   cnt_q;
	logic [LEN_W-1:0]   run_q;
	logic [CAP_W-1:0]   end_q;
	logic [START_W-1:0] found_q;
	logic [START_W-1:0] own_q;
	logic [LEN_W-1:0]   len_q;
	logic [CAP_W-1:0]   cap_q;
	logic               kind_q;
	logic               ok_q;
	logic               rd_v_s1;
	logic [IW-1:0]      rd_idx_s1;

	logic [IW-1:0]      idx;
	logic               used_at;
	logic [LEN_W-1:0]   run_nx;
	logic               hit;
	logic               last;
	logic [CAP_W-1:0]   hit_start;
	logic               req_bad;
	logic               ram_we;
	logic               ram_re;
	logic [START_W-1:0] ram_rdata;
	logic [OCC_W-1:0]   occ;

	assign idx       = IW'(cnt_q);
	assign used_at   = used_q[idx];
	assign run_nx    = used_at ? '0 : run_q + LEN_W'(1);
	assign hit       = (run_nx == len_q);
	assign last      = (cnt_q == cap_q - CAP_W'(1));
	assign hit_start = cnt_q + CAP_W'(1) - CAP_W'(len_q);
	assign req_bad   = (req.run_length == '0) || (CAP_W'(req.run_length) > req.cap);

	// Owner table: one entry per slot, written on fill, read on free
	ffsa_ram #(
		.WIDTH(START_W),
		.DEPTH(SLOTS)
	) u_owner_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx),
		.wdata(found_q),
		.re   (ram_re),
		.raddr(idx),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req.kind == KIND_FREE) begin
						state_nx = (req.cap == '0) ? ST_DONE : ST_FREE_SCAN;
					end else begin
						state_nx = req_bad ? ST_DONE : ST_ALLOC_SCAN;
					end
				end
			end
			ST_ALLOC_SCAN: begin
				if (hit) begin
					state_nx = ST_ALLOC_FILL;
				end else if (last) begin
					state_nx = ST_DONE;
				end
			end
			ST_ALLOC_FILL: begin
				if (cnt_q == end_q) begin
					state_nx = ST_DONE;
				end
			end
			ST_FREE_SCAN: begin
				if (last) begin
					state_nx = ST_FREE_DRAIN;
				end
			end
			ST_FREE_DRAIN: state_nx = ST_DONE;
			ST_DONE: begin
				if (res_ready) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_re = 1'b0;
		unique case (state_q)
			ST_ALLOC_FILL: ram_we = 1'b1;
			ST_FREE_SCAN:  ram_re = 1'b1;
			ST_IDLE, ST_ALLOC_SCAN, ST_FREE_DRAIN, ST_DONE: begin
				ram_we = 1'b0;
			end
			default: ram_re = 1'b0;
		endcase
	end

	for (genvar i = 0; i < OCC_W; i++) begin : g_occ
		if (i < SLOTS) begin : g_on
			assign occ[i] = used_q[i];
		end else begin : g_off
			assign occ[i] = 1'b0;
		end
	end

	assign stat.busy          = (state_q != ST_IDLE);
	assign stat.res_valid     = (state_q == ST_DONE);
	assign stat.alloc         = (kind_q == KIND_ALLOC);
	assign stat.success       = ok_q;
	assign stat.granted_start = (ok_q && kind_q == KIND_ALLOC) ? found_q : '0;
	assign stat.occupancy     = occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			rd_v_s1 <= 1'b0;
			ok_q    <= 1'b0;
			kind_q  <= KIND_ALLOC;
		end else begin
			state_q <= state_nx;
			rd_v_s1 <= (state_q == ST_FREE_SCAN);
			if (state_q == ST_IDLE && start) begin
				kind_q <= req.kind;
				ok_q   <= (req.kind == KIND_FREE);
			end
			if (state_q == ST_ALLOC_FILL) begin
				used_q[idx] <= 1'b1;
				if (cnt_q == end_q) begin
					ok_q <= 1'b1;
				end
			end
			// Owner read data is registered and arrives in the cycle after issue; drop matching slots
			if (rd_v_s1 && ram_rdata == own_q) begin
				used_q[rd_idx_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx;
		unique case (state_q)
			ST_IDLE: begin
				cnt_q   <= '0;
				run_q   <= '0;
				found_q <= '0;
				len_q   <= req.run_length;
				own_q   <= req.run_start;
				cap_q   <= req.cap;
			end
			ST_ALLOC_SCAN: begin
				run_q <= run_nx;
				if (hit) begin
					found_q <= START_W'(hit_start);
					end_q   <= cnt_q;
					cnt_q   <= hit_start;
				end else begin
					cnt_q <= cnt_q + CAP_W'(1);
				end
			end
			ST_ALLOC_FILL, ST_FREE_SCAN: cnt_q <= cnt_q + CAP_W'(1);
			ST_FREE_DRAIN, ST_DONE: run_q <= run_q;
			default: cnt_q <= cnt_q;
		endcase
	end

endmodule

/* design/first_fit_slot_allocator.sv */
// Channel   Direction  Ports                          Payload
// s_axis    in         s_axis_tvalid/tready/tdata/tuser  tuser: kind; tdata: run_length, run_start
// m_axis    out        m_axis_tvalid/tready/tdata     success, granted_start, occupancy
// cfg       in         cfg_we/cfg_wdata               capacity
//
// One request at a time. A free makes one owner read per slot through the owner RAM
// port, then waits for the registered read data; an allocate makes a slot-by-slot
// scan, then one owner write per granted slot. cap is min(capacity, SLOTS, 16);
// rejected requests go straight to the result state.
// Reset clears the occupancy flops at once; the owner RAM needs no clearing pass.
// A stalled result sits in the output register while the next request is taken.
module first_fit_slot_allocator
	import ffsa_pkg::*;
#(
	parameter int unsigned SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,  // [4:0] run_length, [8:5] run_start
	input  logic              s_axis_tuser,  // [0] kind
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [23:0]       m_axis_tdata,  // [0] success, [4:1] granted_start,
	                                         // [20:5] occupancy
	input  logic              cfg_we,
	input  logic [CAP_W-1:0]  cfg_wdata      // capacity
);

	// Scan limit: built slot count, clipped so starts stay 4 bits wide
	localparam int unsigned SCAN_LIM = (SLOTS < MAX_SCAN) ? SLOTS : MAX_SCAN;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

	logic [CAP_W-1:0] capacity_q;
	logic [CAP_W-1:0] cap_eff;
	eng_req_t         req;
	eng_stat_t        stat;
	logic             start;
	logic             res_ready;
	logic             out_valid_q;
	logic [23:0]      out_data_q;

	// Hold capacity; the user must write it only while the engine is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	assign cap_eff = (capacity_q > CAP_W'(SCAN_LIM)) ? CAP_W'(SCAN_LIM) : capacity_q;

	// Accept a request whenever the engine has finished the previous one
	assign s_axis_tready  = !stat.busy;
	assign start          = s_axis_tvalid && s_axis_tready;
	assign req.kind       = s_axis_tuser;
	assign req.run_length = s_axis_tdata[4:0];
	assign req.run_start  = s_axis_tdata[8:5];
	assign req.cap        = cap_eff;

	ffsa_engine #(
		.SLOTS(SLOTS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.res_ready(res_ready),
		.stat     (stat)
	);

	// Output register: advance when empty or when the consumer takes the held result
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= stat.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && stat.res_valid) begin
			out_data_q <= {3'b000, stat.occupancy, stat.granted_start, stat.success};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A granted run always shows its first slot as occupied
	a_grant_marked: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_valid && stat.alloc && stat.success |->
			stat.occupancy[stat.granted_start])
		else $error("granted run start not marked occupied");

	// A failed allocate reports start zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_valid && !stat.success |-> stat.granted_start == '0)
		else $error("failed request reports nonzero start");

	// Occupancy moves only while a request is in work
	a_occ_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.busy |=> $stable(stat.occupancy))
		else $error("occupancy changed while engine idle");

	// No new request enters while a result is still unposted by the engine
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_valid && !res_ready |=> !s_axis_tready)
		else $error("request accepted while result pending in engine");

endmodule
